// ===== sv/deq_pkg.sv =====
// Shared types and codes for the double-ended queue.
`timescale 1ns / 1ps
`default_nettype none
package deq_pkg;

	localparam int WORD_W  = 32;
	localparam int COUNT_W = 5;

	// operation codes carried in the mode field
	localparam logic [2:0] MODE_NONE       = 3'd0;
	localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
	localparam logic [2:0] MODE_PUSH_REAR  = 3'd2;
	localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
	localparam logic [2:0] MODE_POP_REAR   = 3'd4;
	localparam logic [2:0] MODE_CLEAR      = 3'd5;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]               mode;
		logic signed [WORD_W-1:0] value;
	} deq_cmd_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [WORD_W-1:0] popped_word;
		logic signed [WORD_W-1:0] front_word;
		logic signed [WORD_W-1:0] rear_word;
		logic [COUNT_W-1:0]       entry_count;
		logic                     is_empty;
		logic                     is_full;
	} deq_rsp_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic push_front;
		logic push_rear;
		logic pop_front;
		logic pop_rear;
		logic clear;
	} deq_cell_ctl_t;

endpackage
`default_nettype wire

// ===== sv/deq_cell.sv =====
// One storage cell of the shifting deque chain.
`timescale 1ns / 1ps
`default_nettype none
module deq_cell (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire deq_pkg::deq_cell_ctl_t     ctl,
	input  wire logic signed [deq_pkg::WORD_W-1:0] push_word,
	input  wire logic signed [deq_pkg::WORD_W-1:0] prev_data,
	input  wire                             prev_occ,
	input  wire logic signed [deq_pkg::WORD_W-1:0] next_data,
	input  wire                             next_occ,
	output logic signed [deq_pkg::WORD_W-1:0]      data_q,
	output logic                            occ_q,
	output logic                            last
);

	assign last = occ_q && !next_occ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.clear) begin
			occ_q <= 1'b0;
		end else if (ctl.push_front) begin
			occ_q <= prev_occ;
		end else if (ctl.pop_front) begin
			occ_q <= next_occ;
		end else if (ctl.push_rear && !occ_q && prev_occ) begin
			occ_q <= 1'b1;
		end else if (ctl.pop_rear && last) begin
			occ_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push_front) begin
			data_q <= prev_data;
		end else if (ctl.pop_front) begin
			data_q <= next_data;
		end else if (ctl.push_rear && !occ_q && prev_occ) begin
			data_q <= push_word;
		end
	end

endmodule
`default_nettype wire

// ===== sv/deq_ctrl.sv =====
// Operation decode, occupancy count and result register of the deque.
`timescale 1ns / 1ps
`default_nettype none
module deq_ctrl #(
	parameter int DEPTH = 16,
	localparam int CntW = $clog2(DEPTH + 1)
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cmd_valid,
	output logic                            cmd_ready,
	input  wire deq_pkg::deq_cmd_t          cmd,
	output logic                            rsp_valid,
	input  wire                             rsp_ready,
	input  wire logic signed [deq_pkg::WORD_W-1:0] cur_front,
	input  wire logic signed [deq_pkg::WORD_W-1:0] cur_rear,
	output deq_pkg::deq_cell_ctl_t          cell_ctl,
	output logic [1:0]                      status,
	output logic signed [deq_pkg::WORD_W-1:0]      popped,
	output logic [CntW-1:0]                 count
);

	logic                            rsp_valid_q;
	logic [CntW-1:0]                 count_q;
	logic [CntW-1:0]                 count_d;
	logic [1:0]                      status_q;
	logic [1:0]                      status_d;
	logic signed [deq_pkg::WORD_W-1:0] popped_q;
	logic signed [deq_pkg::WORD_W-1:0] popped_d;
	deq_pkg::deq_cell_ctl_t          ctl_d;
	logic                            full;
	logic                            empty;
	logic                            acc;

	assign full      = (count_q == CntW'(DEPTH));
	assign empty     = (count_q == '0);
	assign cmd_ready = !rsp_valid_q || rsp_ready;
	assign acc       = cmd_valid && cmd_ready;

	always_comb begin
		ctl_d    = '0;
		status_d = deq_pkg::ST_OK;
		popped_d = '0;
		count_d  = count_q;
		unique case (cmd.mode)
			deq_pkg::MODE_PUSH_FRONT: begin
				if (full) begin
					status_d = deq_pkg::ST_FULL;
				end else begin
					ctl_d.push_front = 1'b1;
					count_d = count_q + CntW'(1);
				end
			end
			deq_pkg::MODE_PUSH_REAR: begin
				if (full) begin
					status_d = deq_pkg::ST_FULL;
				end else begin
					ctl_d.push_rear = 1'b1;
					count_d = count_q + CntW'(1);
				end
			end
			deq_pkg::MODE_POP_FRONT: begin
				if (empty) begin
					status_d = deq_pkg::ST_EMPTY;
				end else begin
					ctl_d.pop_front = 1'b1;
					popped_d = cur_front;
					count_d = count_q - CntW'(1);
				end
			end
			deq_pkg::MODE_POP_REAR: begin
				if (empty) begin
					status_d = deq_pkg::ST_EMPTY;
				end else begin
					ctl_d.pop_rear = 1'b1;
					popped_d = cur_rear;
					count_d = count_q - CntW'(1);
				end
			end
			deq_pkg::MODE_CLEAR: begin
				ctl_d.clear = 1'b1;
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	assign cell_ctl = acc ? ctl_d : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (acc) begin
				rsp_valid_q <= 1'b1;
				count_q     <= count_d;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q <= status_d;
			popped_q <= popped_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign popped    = popped_q;
	assign count     = count_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(DEPTH))
		else $error("occupancy above depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && cmd.mode == deq_pkg::MODE_PUSH_REAR && !full)
		|=> count_q == $past(count_q) + CntW'(1))
		else $error("push at rear did not grow the count");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status_q == deq_pkg::ST_FULL) |-> count_q == CntW'(DEPTH))
		else $error("full status while not full");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status_q == deq_pkg::ST_EMPTY) |-> count_q == '0)
		else $error("empty status while not empty");
`endif

endmodule
`default_nettype wire

// ===== sv/double_ended_queue_core.sv =====
// Top level of the bounded double-ended queue built as a shifting cell chain.
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) takes one operation per item:
//   none, push front, push rear, pop front, pop rear or clear.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one result per item:
//   status, popped word, front and rear words, count and empty/full flags.
// Latency: the result is valid the cycle after the command is accepted.
// Throughput: one item per cycle while rsp_ready stays high. The cells are
//   updated together at the accepting edge (whole chain shifts for front operations) and
//   the result register is the only buffer, so a new command is taken only
//   when the pending result leaves in the same cycle or none is pending.
// Stall: while rsp_ready is low the result holds and cmd_ready drops.
// Reset: arst_n clears the count and every cell's occupied flag; the queue
//   comes up empty and usable once arst_n is released. Stored words
//   are not cleared; only occupied cells are ever shown.
// Front and rear words are read from the cell chain; the rear is picked by an
//   OR across the cells flagged as last occupied.
`timescale 1ns / 1ps
`default_nettype none
module double_ended_queue_core #(
	parameter int DEPTH = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cmd_valid,
	output logic               cmd_ready,
	input  wire deq_pkg::deq_cmd_t cmd,
	output logic               rsp_valid,
	input  wire                rsp_ready,
	output deq_pkg::deq_rsp_t  rsp
);

	localparam int CntW = $clog2(DEPTH + 1);

	logic signed [deq_pkg::WORD_W-1:0] data_w [DEPTH];
	logic                              occ_w  [DEPTH];
	logic                              last_w [DEPTH];
	logic signed [deq_pkg::WORD_W-1:0] prev_data_w [DEPTH];
	logic                              prev_occ_w  [DEPTH];
	logic signed [deq_pkg::WORD_W-1:0] next_data_w [DEPTH];
	logic                              next_occ_w  [DEPTH];

	deq_pkg::deq_cell_ctl_t            cell_ctl;
	logic signed [deq_pkg::WORD_W-1:0] rear_sel;
	logic signed [deq_pkg::WORD_W-1:0] front_sel;
	logic [1:0]                        status;
	logic signed [deq_pkg::WORD_W-1:0] popped;
	logic [CntW-1:0]                   count;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prev_data_w[i] = cmd.value;
			assign prev_occ_w[i]  = 1'b1;
		end else begin : g_body
			assign prev_data_w[i] = data_w[i-1];
			assign prev_occ_w[i]  = occ_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign next_data_w[i] = '0;
			assign next_occ_w[i]  = 1'b0;
		end else begin : g_inner
			assign next_data_w[i] = data_w[i+1];
			assign next_occ_w[i]  = occ_w[i+1];
		end

		deq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (cell_ctl),
			.push_word (cmd.value),
			.prev_data (prev_data_w[i]),
			.prev_occ  (prev_occ_w[i]),
			.next_data (next_data_w[i]),
			.next_occ  (next_occ_w[i]),
			.data_q    (data_w[i]),
			.occ_q     (occ_w[i]),
			.last      (last_w[i])
		);
	end

	// exactly one cell is flagged last when the queue is non-empty
	always_comb begin
		rear_sel = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_sel = rear_sel | (last_w[i] ? data_w[i] : '0);
		end
	end

	assign front_sel = occ_w[0] ? data_w[0] : '0;

	deq_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cur_front (front_sel),
		.cur_rear  (rear_sel),
		.cell_ctl  (cell_ctl),
		.status    (status),
		.popped    (popped),
		.count     (count)
	);

	// cells hold the post-operation state while the result is pending
	always_comb begin
		rsp.status      = status;
		rsp.popped_word = popped;
		rsp.front_word  = front_sel;
		rsp.rear_word   = rear_sel;
		rsp.entry_count = deq_pkg::COUNT_W'(count);
		rsp.is_empty    = (count == '0);
		rsp.is_full     = (count == CntW'(DEPTH));
	end

endmodule
`default_nettype wire

// ===== test/tb_double_ended_queue_core.sv =====
// Self-checking testbench for the bounded double-ended queue core.
`timescale 1ns / 1ps
`default_nettype none
module tb_double_ended_queue_core;

	localparam int DEPTH = 16;
	localparam int RANDOM_ITEMS = 900;
	localparam int HOLD_CYCLES = 60;
	localparam int MAX_PRINTS = 50;
	// modes with no operation assigned; the block treats them as a query
	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;

	typedef struct {
		logic [2:0]         mode;
		logic [31:0]        value;
		int                 reps;
		bit                 pinned;
		deq_pkg::deq_rsp_t  pin;
	} step_row_t;

	typedef struct {
		bit                pinned;
		deq_pkg::deq_rsp_t pin;
	} order_note_t;

	logic              clk;
	logic              arst_n;
	logic              cmd_valid;
	logic              cmd_ready;
	deq_pkg::deq_cmd_t cmd;
	logic              rsp_valid;
	logic              rsp_ready;
	deq_pkg::deq_rsp_t rsp;

	// shadow copy of the deque
	logic signed [deq_pkg::WORD_W-1:0] shadow_words [DEPTH];
	int shadow_head = 0;
	int shadow_fill = 0;

	deq_pkg::deq_rsp_t rsp_expected [$];
	order_note_t       order_notes [$];
	step_row_t         script [$];
	int errors = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;

	double_ended_queue_core #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (errors < MAX_PRINTS)
			$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		errors++;
	endtask

	// applies one operation to the shadow deque, returns the result it yields
	function automatic deq_pkg::deq_rsp_t deque_step(deq_pkg::deq_cmd_t c);
		deq_pkg::deq_rsp_t r;
		r = '0;
		case (c.mode)
			deq_pkg::MODE_PUSH_FRONT, deq_pkg::MODE_PUSH_REAR: begin
				if (shadow_fill >= DEPTH) begin
					r.status = deq_pkg::ST_FULL;
				end else if (c.mode == deq_pkg::MODE_PUSH_FRONT) begin
					shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
					shadow_words[shadow_head] = c.value;
					shadow_fill++;
				end else begin
					shadow_words[(shadow_head + shadow_fill) % DEPTH] = c.value;
					shadow_fill++;
				end
			end
			deq_pkg::MODE_POP_FRONT: begin
				if (shadow_fill == 0) begin
					r.status = deq_pkg::ST_EMPTY;
				end else begin
					r.popped_word = shadow_words[shadow_head];
					shadow_head = (shadow_head + 1) % DEPTH;
					shadow_fill--;
				end
			end
			deq_pkg::MODE_POP_REAR: begin
				if (shadow_fill == 0) begin
					r.status = deq_pkg::ST_EMPTY;
				end else begin
					r.popped_word = shadow_words[(shadow_head + shadow_fill - 1) % DEPTH];
					shadow_fill--;
				end
			end
			deq_pkg::MODE_CLEAR: begin
				shadow_head = 0;
				shadow_fill = 0;
			end
			default: begin
			end
		endcase
		if (shadow_fill != 0) begin
			r.front_word = shadow_words[shadow_head];
			r.rear_word  = shadow_words[(shadow_head + shadow_fill - 1) % DEPTH];
		end
		r.entry_count = shadow_fill[deq_pkg::COUNT_W-1:0];
		r.is_empty    = (shadow_fill == 0);
		r.is_full     = (shadow_fill >= DEPTH);
		return r;
	endfunction

	function automatic deq_pkg::deq_rsp_t mk_rsp(logic [1:0] st, logic [31:0] front,
			logic [31:0] rear, int n);
		deq_pkg::deq_rsp_t r;
		r.status      = st;
		r.popped_word = '0;
		r.front_word  = front;
		r.rear_word   = rear;
		r.entry_count = n[deq_pkg::COUNT_W-1:0];
		r.is_empty    = (n == 0);
		r.is_full     = (n >= DEPTH);
		return r;
	endfunction

	function automatic void add_step(logic [2:0] mode, logic [31:0] value, int reps);
		step_row_t s;
		s.mode   = mode;
		s.value  = value;
		s.reps   = reps;
		s.pinned = 1'b0;
		s.pin    = '0;
		script.push_back(s);
	endfunction

	function automatic void add_pinned(logic [2:0] mode, logic [31:0] value,
			deq_pkg::deq_rsp_t pin);
		step_row_t s;
		s.mode   = mode;
		s.value  = value;
		s.reps   = 1;
		s.pinned = 1'b1;
		s.pin    = pin;
		script.push_back(s);
	endfunction

	task automatic check_rsp(deq_pkg::deq_rsp_t got, deq_pkg::deq_rsp_t want);
		if (got.status !== want.status) note_mismatch("status", got.status, want.status);
		if (got.popped_word !== want.popped_word)
			note_mismatch("popped_word", got.popped_word, want.popped_word);
		if (got.front_word !== want.front_word)
			note_mismatch("front_word", got.front_word, want.front_word);
		if (got.rear_word !== want.rear_word)
			note_mismatch("rear_word", got.rear_word, want.rear_word);
		if (got.entry_count !== want.entry_count)
			note_mismatch("entry_count", got.entry_count, want.entry_count);
		if (got.is_empty !== want.is_empty)
			note_mismatch("is_empty", got.is_empty, want.is_empty);
		if (got.is_full !== want.is_full) note_mismatch("is_full", got.is_full, want.is_full);
	endtask

	// sampled before the block's own updates at this edge land
	always @(posedge clk) begin
		deq_pkg::deq_rsp_t predicted;
		order_note_t       note;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (rsp_expected.size() == 0)
					note_mismatch("result with nothing expected", rsp.status, '0);
				else
					check_rsp(rsp, rsp_expected.pop_front());
			end
			if (cmd_valid && cmd_ready) begin
				predicted = deque_step(cmd);
				note = order_notes.pop_front();
				rsp_expected.push_back(note.pinned ? note.pin : predicted);
			end
		end
	end

	// result side: random stalls, a quiet window, and one long hold-off
	initial begin
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				rsp_ready <= calm || ($urandom_range(99) >= 20);
			end
		end
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(deq_pkg::deq_cmd_t c, bit pinned, deq_pkg::deq_rsp_t pin);
		order_note_t note;
		while (!calm && $urandom_range(99) < 20) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		note.pinned = pinned;
		note.pin    = pin;
		order_notes.push_back(note);
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// alternating growth and drain phases so the deque keeps hitting both ends
	function automatic logic [2:0] pick_mode(bit growing);
		int r;
		r = $urandom_range(99);
		if (r < (growing ? 35 : 12)) return deq_pkg::MODE_PUSH_FRONT;
		if (r < (growing ? 70 : 24)) return deq_pkg::MODE_PUSH_REAR;
		if (r < (growing ? 80 : 57)) return deq_pkg::MODE_POP_FRONT;
		if (r < 90) return deq_pkg::MODE_POP_REAR;
		if (r < 96) return deq_pkg::MODE_NONE;
		if (r < 98) return $urandom_range(1) ? MODE_SPARE6 : MODE_SPARE7;
		return deq_pkg::MODE_CLEAR;
	endfunction

	initial begin
		deq_pkg::deq_cmd_t c;
		int hold_at;
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_pinned(deq_pkg::MODE_NONE, 32'h0,
			mk_rsp(deq_pkg::ST_OK, 32'h0, 32'h0, 0));
		add_pinned(deq_pkg::MODE_POP_FRONT, 32'h1234_5678,
			mk_rsp(deq_pkg::ST_EMPTY, 32'h0, 32'h0, 0));
		add_pinned(deq_pkg::MODE_POP_REAR, 32'hFFFF_FFFF,
			mk_rsp(deq_pkg::ST_EMPTY, 32'h0, 32'h0, 0));
		add_pinned(deq_pkg::MODE_PUSH_REAR, 32'h7FFF_FFFF,
			mk_rsp(deq_pkg::ST_OK, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
		add_pinned(deq_pkg::MODE_PUSH_FRONT, 32'h8000_0000,
			mk_rsp(deq_pkg::ST_OK, 32'h8000_0000, 32'h7FFF_FFFF, 2));
		add_step(deq_pkg::MODE_PUSH_REAR, 32'hFFFF_FFFF, 1);
		add_step(deq_pkg::MODE_PUSH_FRONT, 32'h0, 1);
		add_step(MODE_SPARE6, 32'h5A5A_5A5A, 1);
		add_step(MODE_SPARE7, 32'hA5A5_A5A5, 1);
		add_pinned(deq_pkg::MODE_CLEAR, 32'h0, mk_rsp(deq_pkg::ST_OK, 32'h0, 32'h0, 0));
		// fill with an ascending run, then push into the full deque from both ends
		add_step(deq_pkg::MODE_PUSH_REAR, 32'h1000_0000, DEPTH);
		add_pinned(deq_pkg::MODE_PUSH_FRONT, 32'h5555_5555,
			mk_rsp(deq_pkg::ST_FULL, 32'h1000_0000, 32'h1000_000F, DEPTH));
		add_pinned(deq_pkg::MODE_PUSH_REAR, 32'h5555_5555,
			mk_rsp(deq_pkg::ST_FULL, 32'h1000_0000, 32'h1000_000F, DEPTH));
		add_step(deq_pkg::MODE_POP_FRONT, 32'h0, 3);
		add_step(deq_pkg::MODE_PUSH_FRONT, 32'h2000_0000, 2);
		add_step(deq_pkg::MODE_POP_REAR, 32'h0, 1);
		add_pinned(deq_pkg::MODE_CLEAR, 32'hFFFF_FFFF,
			mk_rsp(deq_pkg::ST_OK, 32'h0, 32'h0, 0));

		foreach (script[k]) begin
			for (int rep = 0; rep < script[k].reps; rep++) begin
				c.mode  = script[k].mode;
				c.value = script[k].value + rep;
				send_item(c, script[k].pinned, script[k].pin);
			end
		end

		hold_at = $urandom_range(500, 700);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			calm = (i >= 300 && i < 450);
			if (i == hold_at) hold_req = 1'b1;
			c.mode  = pick_mode(((i / 48) % 2) == 0);
			c.value = pick_value();
			send_item(c, 1'b0, '0);
		end
		cmd_valid <= 1'b0;
		calm = 1'b0;

		while (rsp_expected.size() != 0) @(posedge clk);
		repeat (5) @(posedge clk);
		if (errors == 0 && rsp_expected.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
`default_nettype wire
